[rtl/core/rct_pkg.sv]
// ----------------------------------------------------------------------------
// rct_pkg
// Types, codes and fixed widths shared by the reassembly context table.
// ----------------------------------------------------------------------------
package rct_pkg;

  localparam int ADDR_W   = 16;
  localparam int LINK_W   = 7;
  localparam int LEN_W    = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int OFS_W    = 13;

  // key = 100*quot + rem with rem < 100; quot < 21*65536 + 1
  localparam int QUOT_W = 21;
  localparam int REM_W  = 7;

  localparam logic [QUOT_W-1:0] MUL_SRC  = QUOT_W'(13);
  localparam logic [QUOT_W-1:0] MUL_DEST = QUOT_W'(7);
  localparam logic [LINK_W-1:0] KEY_BASE = LINK_W'(100);

  localparam logic OP_SAVE  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FETCHED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd6;

  localparam int             PADDR_W          = 3;
  localparam logic           REG_MAX_PAYLOAD  = 1'b0;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = LEN_W'(1024);

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] seq_num;
    logic [LINK_W-1:0] arrival_link;
    logic [LEN_W-1:0]  frag_length;
  } req_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/rct_req_if.sv]
// ----------------------------------------------------------------------------
// rct_req_if
// Request channel: save or fetch transaction into the context table.
// ----------------------------------------------------------------------------
interface rct_req_if;

  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [rct_pkg::ADDR_W-1:0]    src_addr;
  logic [rct_pkg::ADDR_W-1:0]    dest_addr;
  logic [rct_pkg::ADDR_W-1:0]    seq_num;
  logic [rct_pkg::LINK_W-1:0]    arrival_link;
  logic [rct_pkg::LEN_W-1:0]     frag_length;

  modport source (
    output valid, op, src_addr, dest_addr, seq_num, arrival_link, frag_length,
    input  ready
  );

  modport sink (
    input  valid, op, src_addr, dest_addr, seq_num, arrival_link, frag_length,
    output ready
  );

endinterface

[rtl/core/rct_rsp_if.sv]
// ----------------------------------------------------------------------------
// rct_rsp_if
// Response channel: one result transaction per request.
// ----------------------------------------------------------------------------
interface rct_rsp_if;

  logic                           valid;
  logic                           ready;
  logic [rct_pkg::STATUS_W-1:0]   status;
  logic [rct_pkg::SLOT_W-1:0]     slot;
  logic [rct_pkg::OFS_W-1:0]      write_offset;
  logic [rct_pkg::OFS_W-1:0]      total_length;

  modport source (
    output valid, status, slot, write_offset, total_length,
    input  ready
  );

  modport sink (
    input  valid, status, slot, write_offset, total_length,
    output ready
  );

endinterface

[rtl/core/rct_cfg.sv]
// ----------------------------------------------------------------------------
// rct_cfg
// APB register file holding the payload limit.
// ----------------------------------------------------------------------------
module rct_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rct_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [rct_pkg::LEN_W-1:0]    max_payload
);

  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[rct_pkg::PADDR_W-1] == rct_pkg::REG_MAX_PAYLOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= rct_pkg::MAX_PAYLOAD_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_payload <= pwdata[rct_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(32-rct_pkg::LEN_W){1'b0}}, max_payload};
    end
  end

endmodule

[rtl/core/rct_ctrl.sv]
// ----------------------------------------------------------------------------
// rct_ctrl
// Sequencer: accept, scan every slot, finish the compare, commit result.
// ----------------------------------------------------------------------------
module rct_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  rct_pkg::sts_t   sts,
  output rct_pkg::cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.idx_last) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/rct_dp.sv]
// ----------------------------------------------------------------------------
// rct_dp
// Datapath: key build, context store, slot scan, result and output register.
// ----------------------------------------------------------------------------
module rct_dp #(
  parameter int ENTRIES   = 16,
  parameter int MSG_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rct_pkg::cmd_t                 cmd,
  output rct_pkg::sts_t                 sts,
  input  rct_pkg::req_t                 req,
  input  logic [rct_pkg::LEN_W-1:0]     max_payload,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [rct_pkg::STATUS_W-1:0]  rsp_status,
  output logic [rct_pkg::SLOT_W-1:0]    rsp_slot,
  output logic [rct_pkg::OFS_W-1:0]     rsp_write_offset,
  output logic [rct_pkg::OFS_W-1:0]     rsp_total_length
);

  localparam int IW  = $clog2(ENTRIES);
  localparam int LW  = $clog2(MSG_BYTES + 1);
  localparam int SW  = ((LW > rct_pkg::LEN_W) ? LW : rct_pkg::LEN_W) + 1;
  localparam int QW  = rct_pkg::QUOT_W;
  localparam int RW  = rct_pkg::REM_W;

  // context store
  logic [QW-1:0] mem_quot [ENTRIES];
  logic [RW-1:0] mem_rem  [ENTRIES];
  logic [LW-1:0] mem_len  [ENTRIES];
  logic [ENTRIES-1:0] valid;

  logic [QW-1:0] rd_quot;
  logic [RW-1:0] rd_rem;
  logic [LW-1:0] rd_len;

  // captured transaction
  logic                      op;
  logic [rct_pkg::LEN_W-1:0] frag_len;
  logic [QW-1:0]             key_quot;
  logic [RW-1:0]             key_rem;

  // scan
  logic [IW-1:0] idx;
  logic [IW-1:0] cmp_idx;
  logic          cmp_en;
  logic          hit_found;
  logic [IW-1:0] hit_idx;
  logic [LW-1:0] hit_len;
  logic          free_found;
  logic [IW-1:0] free_idx;

  // key build
  logic [QW-1:0] quot_calc;
  logic [RW-1:0] rem_calc;
  logic          link_hi;

  // decision
  logic [SW-1:0]               sum;
  logic [rct_pkg::STATUS_W-1:0] res_status;
  logic [IW-1:0]               res_idx;
  logic [rct_pkg::OFS_W-1:0]   res_ofs;
  logic [rct_pkg::OFS_W-1:0]   res_tot;
  logic                        wr_len;
  logic                        wr_new;
  logic [IW-1:0]               wr_idx;
  logic [LW-1:0]               wr_len_val;

  logic quot_eq;
  logic key_eq;

  assign link_hi   = (req.arrival_link >= rct_pkg::KEY_BASE);
  assign quot_calc = QW'(req.src_addr) * rct_pkg::MUL_SRC
                   + QW'(req.dest_addr) * rct_pkg::MUL_DEST
                   + QW'(req.seq_num) + QW'(link_hi);
  assign rem_calc  = link_hi ? (req.arrival_link - rct_pkg::KEY_BASE) : req.arrival_link;

  assign sts.idx_last = (idx == IW'(ENTRIES - 1));
  assign sts.out_free = !rsp_valid || rsp_ready;

  assign quot_eq = (rd_quot == key_quot);
  assign key_eq  = quot_eq && (rd_rem == key_rem);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op       <= req.op;
      frag_len <= req.frag_length;
      key_quot <= quot_calc;
      key_rem  <= rem_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_quot <= mem_quot[idx];
      rd_rem  <= mem_rem[idx];
      rd_len  <= mem_len[idx];
    end
    if (wr_len) begin
      mem_len[wr_idx] <= wr_len_val;
    end
    if (wr_new) begin
      mem_quot[wr_idx] <= key_quot;
      mem_rem[wr_idx]  <= key_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      cmp_en     <= 1'b0;
      cmp_idx    <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      valid      <= '0;
    end else begin
      cmp_en <= cmd.issue;
      if (cmd.start) begin
        idx        <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else if (cmd.issue) begin
        idx     <= idx + 1'b1;
        cmp_idx <= idx;
      end
      if (cmp_en) begin
        if (valid[cmp_idx]) begin
          if (key_eq && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx   <= cmp_idx;
            hit_len   <= rd_len;
          end
          if (op == rct_pkg::OP_FETCH && quot_eq) begin
            valid[cmp_idx] <= 1'b0;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
      if (wr_new) begin
        valid[wr_idx] <= 1'b1;
      end
    end
  end

  always_comb begin
    sum        = SW'(hit_len) + SW'(frag_len);
    res_status = rct_pkg::ST_DROPPED;
    res_idx    = '0;
    res_ofs    = '0;
    res_tot    = '0;
    wr_len     = 1'b0;
    wr_new     = 1'b0;
    wr_idx     = hit_idx;
    wr_len_val = LW'(sum);
    if (op == rct_pkg::OP_FETCH) begin
      if (hit_found) begin
        res_status = rct_pkg::ST_FETCHED;
        res_idx    = hit_idx;
        res_tot    = rct_pkg::OFS_W'(hit_len);
      end else begin
        res_status = rct_pkg::ST_NOT_FOUND;
      end
    end else if (frag_len > max_payload) begin
      res_status = rct_pkg::ST_DROPPED;
    end else if (hit_found) begin
      res_idx = hit_idx;
      res_ofs = rct_pkg::OFS_W'(hit_len);
      if (sum > SW'(MSG_BYTES)) begin
        res_status = rct_pkg::ST_OVERFLOW;
        res_tot    = rct_pkg::OFS_W'(hit_len);
      end else begin
        res_status = rct_pkg::ST_APPENDED;
        res_tot    = rct_pkg::OFS_W'(sum);
        wr_len     = cmd.commit;
      end
    end else if (!free_found) begin
      res_status = rct_pkg::ST_FULL;
    end else if (SW'(frag_len) > SW'(MSG_BYTES)) begin
      res_status = rct_pkg::ST_OVERFLOW;
      res_idx    = free_idx;
    end else begin
      res_status = rct_pkg::ST_NEW;
      res_idx    = free_idx;
      res_tot    = rct_pkg::OFS_W'(frag_len);
      wr_idx     = free_idx;
      wr_len_val = LW'(frag_len);
      wr_len     = cmd.commit;
      wr_new     = cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_status       <= res_status;
      rsp_slot         <= rct_pkg::SLOT_W'(res_idx);
      rsp_write_offset <= res_ofs;
      rsp_total_length <= res_tot;
    end
  end

endmodule

[rtl/core/reassembly_context_table.sv]
// ----------------------------------------------------------------------------
// reassembly_context_table
// Reassembly context table: save fragments, fetch and release messages.
// ----------------------------------------------------------------------------
//   channel  kind        role
//   req      rct_req_if  sink    save / fetch transaction
//   rsp      rct_rsp_if  source  one result transaction per request
//   apb      APB-style   slave   max_payload at 0x0
//
// Each item runs through accept, a scan of every slot of the context store
// (single read port), a compare tail and a commit, before the next is taken.
// rst is synchronous: contexts are all freed, max_payload returns to 1024.
// A new request is accepted while a result still waits on rsp; the commit of
// the next one waits until the output register is free.
// ----------------------------------------------------------------------------
module reassembly_context_table #(
  parameter int ENTRIES   = 16,
  parameter int MSG_BYTES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  rct_req_if.sink                      req,
  rct_rsp_if.source                    rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rct_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  rct_pkg::cmd_t             cmd;
  rct_pkg::sts_t             sts;
  rct_pkg::req_t             req_data;
  logic [rct_pkg::LEN_W-1:0] max_payload;
  logic                      req_ready;

  assign req.ready = req_ready;

  assign req_data.op           = req.op;
  assign req_data.src_addr     = req.src_addr;
  assign req_data.dest_addr    = req.dest_addr;
  assign req_data.seq_num      = req.seq_num;
  assign req_data.arrival_link = req.arrival_link;
  assign req_data.frag_length  = req.frag_length;

  rct_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  rct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rct_dp #(
    .ENTRIES   (ENTRIES),
    .MSG_BYTES (MSG_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .req              (req_data),
    .max_payload      (max_payload),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_slot         (rsp.slot),
    .rsp_write_offset (rsp.write_offset),
    .rsp_total_length (rsp.total_length)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the reassembly context table. Save and fetch
// transactions go in through the request channel. A local model of the
// context store predicts every result, and each response is checked against
// it. Directed cases come first, then randomised phases under different
// max_payload settings, most with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SLOTS     = 16;
  localparam int MSG_MAX   = 4096;
  localparam int POOL_N    = 20;
  localparam int LIMIT     = 600000;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [rct_pkg::STATUS_W-1:0] status;
    logic [rct_pkg::SLOT_W-1:0]   slot;
    logic [rct_pkg::OFS_W-1:0]    write_offset;
    logic [rct_pkg::OFS_W-1:0]    total_length;
  } ctx_result_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [rct_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  rct_req_if req_ch ();
  rct_rsp_if rsp_ch ();

  reassembly_context_table u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // local copy of the context store
  bit                        ctx_valid [SLOTS];
  logic [31:0]               ctx_key   [SLOTS];
  int                        ctx_len   [SLOTS];
  rct_pkg::req_t             ctx_owner [SLOTS];
  logic [rct_pkg::LEN_W-1:0] payload_limit;

  ctx_result_t   awaited_results [$];
  rct_pkg::req_t ident_pool [POOL_N];
  int            src_gap_pct;
  int            sink_stall_pct;
  int            mismatches  = 0;
  int            cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("** reassembly_context_table: FAILED **");
      $finish;
    end
  end

  function automatic ctx_result_t predict_context_op(input rct_pkg::req_t rq);
    logic [31:0] id;
    int          hit;
    int          fre;
    int          sum;
    ctx_result_t r;
    id = 100 * (13 * 32'(rq.src_addr) + 7 * 32'(rq.dest_addr) + 32'(rq.seq_num))
         + 32'(rq.arrival_link);
    hit = -1;
    fre = -1;
    r = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (ctx_valid[i]) begin
        if (hit < 0 && ctx_key[i] == id) hit = i;
      end else if (fre < 0) begin
        fre = i;
      end
    end
    if (rq.op == rct_pkg::OP_SAVE) begin
      if (rq.frag_length > payload_limit) begin
        r.status = rct_pkg::ST_DROPPED;
      end else if (hit >= 0) begin
        sum = ctx_len[hit] + int'(rq.frag_length);
        r.slot = rct_pkg::SLOT_W'(hit);
        r.write_offset = rct_pkg::OFS_W'(ctx_len[hit]);
        if (sum > MSG_MAX) begin
          r.status = rct_pkg::ST_OVERFLOW;
          r.total_length = rct_pkg::OFS_W'(ctx_len[hit]);
        end else begin
          r.status = rct_pkg::ST_APPENDED;
          r.total_length = rct_pkg::OFS_W'(sum);
          ctx_len[hit] = sum;
        end
      end else if (fre < 0) begin
        r.status = rct_pkg::ST_FULL;
      end else if (rq.frag_length > MSG_MAX) begin
        r.status = rct_pkg::ST_OVERFLOW;
        r.slot = rct_pkg::SLOT_W'(fre);
      end else begin
        r.status = rct_pkg::ST_NEW;
        r.slot = rct_pkg::SLOT_W'(fre);
        r.total_length = rct_pkg::OFS_W'(rq.frag_length);
        ctx_valid[fre] = 1'b1;
        ctx_key[fre] = id;
        ctx_len[fre] = int'(rq.frag_length);
        ctx_owner[fre] = rq;
      end
    end else begin
      if (hit >= 0) begin
        r.status = rct_pkg::ST_FETCHED;
        r.slot = rct_pkg::SLOT_W'(hit);
        r.total_length = rct_pkg::OFS_W'(ctx_len[hit]);
      end else begin
        r.status = rct_pkg::ST_NOT_FOUND;
      end
      // release the whole message group
      for (int i = 0; i < SLOTS; i++) begin
        if (ctx_valid[i] && ctx_key[i] / 100 == id / 100) ctx_valid[i] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic rct_pkg::req_t make_req(input logic op,
                                             input logic [rct_pkg::ADDR_W-1:0] src,
                                             input logic [rct_pkg::ADDR_W-1:0] dst,
                                             input logic [rct_pkg::ADDR_W-1:0] seq,
                                             input logic [rct_pkg::LINK_W-1:0] link,
                                             input logic [rct_pkg::LEN_W-1:0] len);
    rct_pkg::req_t rq;
    rq.op = op;
    rq.src_addr = src;
    rq.dest_addr = dst;
    rq.seq_num = seq;
    rq.arrival_link = link;
    rq.frag_length = len;
    return rq;
  endfunction

  function automatic rct_pkg::req_t rand_ident();
    return make_req(rct_pkg::OP_SAVE, rct_pkg::ADDR_W'($urandom()),
                    rct_pkg::ADDR_W'($urandom()), rct_pkg::ADDR_W'($urandom()),
                    rct_pkg::LINK_W'($urandom_range(127)), '0);
  endfunction

  function automatic logic [rct_pkg::LEN_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return rct_pkg::LEN_W'($urandom_range(600));
    if (roll < 85) return rct_pkg::LEN_W'($urandom_range(int'(payload_limit)));
    if (roll < 95) return payload_limit + rct_pkg::LEN_W'($urandom_range(1));
    return rct_pkg::LEN_W'($urandom());
  endfunction

  // fetch of a live context (a pool identity if none is live), so the store does not clog up
  function automatic rct_pkg::req_t release_target();
    int            live [$];
    rct_pkg::req_t rq;
    for (int i = 0; i < SLOTS; i++) begin
      if (ctx_valid[i]) live.push_back(i);
    end
    if (live.size() == 0) rq = ident_pool[$urandom_range(POOL_N - 1)];
    else rq = ctx_owner[live[$urandom_range(live.size() - 1)]];
    rq.op = rct_pkg::OP_FETCH;
    return rq;
  endfunction

  // identities in groups of five: two plain, one with the fields of its
  // neighbour but a new link, and a pair with equal keys through a link above 99
  function automatic void build_pool();
    rct_pkg::req_t x;
    for (int i = 0; i < POOL_N; i++) begin
      case (i % 5)
        0, 1: begin
          ident_pool[i] = rand_ident();
        end
        2: begin
          ident_pool[i] = ident_pool[i - 1];
          ident_pool[i].arrival_link = rct_pkg::LINK_W'($urandom_range(127));
        end
        3: begin
          x = rand_ident();
          x.seq_num = rct_pkg::ADDR_W'($urandom_range(65534));
          x.arrival_link = rct_pkg::LINK_W'($urandom_range(127, 100));
          ident_pool[i] = x;
        end
        default: begin
          x = ident_pool[i - 1];
          x.seq_num = x.seq_num + 1'b1;
          x.arrival_link = x.arrival_link - rct_pkg::LINK_W'(100);
          ident_pool[i] = x;
        end
      endcase
    end
  endfunction

  task automatic issue_request(input rct_pkg::req_t rq);
    int n;
    if (src_gap_pct > 0 && $urandom_range(99) < src_gap_pct) begin
      n = $urandom_range(18, 1);
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.op           <= rq.op;
    req_ch.src_addr     <= rq.src_addr;
    req_ch.dest_addr    <= rq.dest_addr;
    req_ch.seq_num      <= rq.seq_num;
    req_ch.arrival_link <= rq.arrival_link;
    req_ch.frag_length  <= rq.frag_length;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    awaited_results.push_back(predict_context_op(rq));
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic write_max_payload(input logic [rct_pkg::LEN_W-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rct_pkg::PADDR_W'(4 * int'(rct_pkg::REG_MAX_PAYLOAD));
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    payload_limit = value;
  endtask

  function automatic rct_pkg::req_t release_target_of(input int i);
    rct_pkg::req_t rq;
    rq = ctx_owner[i];
    rq.op = rct_pkg::OP_FETCH;
    return rq;
  endfunction

  task automatic clear_contexts();
    for (int i = 0; i < SLOTS; i++) begin
      if (ctx_valid[i]) issue_request(release_target_of(i));
    end
  endtask

  task automatic test_new_and_append();
    rct_pkg::req_t rq;
    rq = make_req(rct_pkg::OP_SAVE, '1, '1, '1, rct_pkg::LINK_W'(127),
                  rct_pkg::LEN_W'(1024));
    issue_request(rq);
    rq.frag_length = '0;
    issue_request(rq);
    rq.frag_length = rct_pkg::LEN_W'(1025);
    issue_request(rq);
  endtask

  task automatic test_link_alias();
    issue_request(make_req(rct_pkg::OP_SAVE, '0, '0, '0, rct_pkg::LINK_W'(100),
                           rct_pkg::LEN_W'(1000)));
    issue_request(make_req(rct_pkg::OP_SAVE, '0, '0, rct_pkg::ADDR_W'(1), '0,
                           rct_pkg::LEN_W'(24)));
    issue_request(make_req(rct_pkg::OP_SAVE, '0, '0, rct_pkg::ADDR_W'(1),
                           rct_pkg::LINK_W'(99), rct_pkg::LEN_W'(5)));
  endtask

  task automatic test_append_overflow();
    rct_pkg::req_t rq;
    rq = make_req(rct_pkg::OP_SAVE, '1, '1, '1, rct_pkg::LINK_W'(127),
                  rct_pkg::LEN_W'(1024));
    repeat (3) issue_request(rq);
    rq.frag_length = rct_pkg::LEN_W'(1);
    issue_request(rq);
  endtask

  task automatic test_fetch_release();
    issue_request(make_req(rct_pkg::OP_FETCH, '0, '0, rct_pkg::ADDR_W'(1),
                           rct_pkg::LINK_W'(99), '1));
    issue_request(make_req(rct_pkg::OP_FETCH, '0, '0, rct_pkg::ADDR_W'(1), '0, '0));
  endtask

  task automatic test_new_overflow();
    rct_pkg::req_t rq;
    rq = rand_ident();
    write_max_payload('1);
    rq.frag_length = '1;
    issue_request(rq);
    rq.frag_length = rct_pkg::LEN_W'(MSG_MAX);
    issue_request(rq);
    rq.frag_length = '0;
    issue_request(rq);
    write_max_payload('0);
    rq.frag_length = rct_pkg::LEN_W'(1);
    issue_request(rq);
    issue_request(rand_ident());
  endtask

  task automatic test_table_full();
    rct_pkg::req_t rq;
    int            free_n;
    rq = rand_ident();
    rq.arrival_link = '0;
    free_n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!ctx_valid[i]) free_n++;
    end
    repeat (free_n) begin
      issue_request(rq);
      rq.arrival_link = rq.arrival_link + 1'b1;
    end
    issue_request(rq);
    // append still goes through on a full store
    issue_request(make_req(rct_pkg::OP_SAVE, '1, '1, '1, rct_pkg::LINK_W'(127), '0));
    rq.arrival_link = '0;
    rq.op = rct_pkg::OP_FETCH;
    issue_request(rq);
    clear_contexts();
  endtask

  task automatic run_random_phase(input logic [rct_pkg::LEN_W-1:0] limit,
                                  input int count,
                                  input int gap_pct, input int stall_pct);
    rct_pkg::req_t rq;
    int            roll;
    write_max_payload(limit);
    src_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    build_pool();
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        rq = ident_pool[$urandom_range(POOL_N - 1)];
        rq.op = rct_pkg::OP_SAVE;
        rq.frag_length = pick_length();
      end else if (roll < 82) begin
        rq = ident_pool[$urandom_range(POOL_N - 1)];
        rq.op = rct_pkg::OP_FETCH;
        rq.frag_length = rct_pkg::LEN_W'($urandom());
      end else if (roll < 90) begin
        rq = release_target();
      end else begin
        rq = rand_ident();
        rq.op = ($urandom_range(1) == 0) ? rct_pkg::OP_SAVE : rct_pkg::OP_FETCH;
        rq.frag_length = pick_length();
      end
      issue_request(rq);
      if ($urandom_range(99) == 0) drain_results();
    end
    clear_contexts();
  endtask

  initial begin : rsp_sink
    int n;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && sink_stall_pct > 0 && $urandom_range(99) < sink_stall_pct) begin
        n = $urandom_range(18, 1);
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    ctx_result_t want;
    ctx_result_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status = rsp_ch.status;
      got.slot = rsp_ch.slot;
      got.write_offset = rsp_ch.write_offset;
      got.total_length = rsp_ch.total_length;
      if (awaited_results.size() == 0) begin
        if (mismatches < MAX_SHOWN)
          $display("%0t unexpected transaction: status %0d slot %0d offset %0d length %0d",
                   $realtime, got.status, got.slot, got.write_offset, got.total_length);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.write_offset !== want.write_offset ||
            got.total_length !== want.total_length) begin
          if (mismatches < MAX_SHOWN)
            $display("%0t mismatch: status %0d/%0d slot %0d/%0d offset %0d/%0d length %0d/%0d",
                     $realtime, want.status, got.status, want.slot, got.slot,
                     want.write_offset, got.write_offset, want.total_length,
                     got.total_length);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.op           <= rct_pkg::OP_SAVE;
    req_ch.src_addr     <= '0;
    req_ch.dest_addr    <= '0;
    req_ch.seq_num      <= '0;
    req_ch.arrival_link <= '0;
    req_ch.frag_length  <= '0;
    src_gap_pct = 25;
    sink_stall_pct = 4;
    payload_limit = rct_pkg::MAX_PAYLOAD_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_new_and_append();
    test_link_alias();
    test_append_overflow();
    test_fetch_release();
    test_new_overflow();
    test_table_full();

    run_random_phase(rct_pkg::LEN_W'(1024), 300, 25, 4);
    run_random_phase('1, 250, 25, 4);
    run_random_phase('0, 60, 25, 4);
    run_random_phase(rct_pkg::LEN_W'(MSG_MAX), 250, 0, 0);
    run_random_phase(rct_pkg::LEN_W'($urandom()), 250, 30, 6);
    run_random_phase(rct_pkg::LEN_W'(MSG_MAX + 1), 250, 25, 4);
    run_random_phase(rct_pkg::LEN_W'($urandom()), 200, 10, 2);
    run_random_phase(rct_pkg::LEN_W'(1024), 200, 0, 0);

    drain_results();
    repeat (2 * (SLOTS + 3)) @(posedge clk);
    if (mismatches == 0) begin
      $display("** reassembly_context_table: PASSED **");
    end else begin
      $display("** reassembly_context_table: FAILED **");
    end
    $finish;
  end

endmodule
